// File: src/jssp_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers for the json syntax stack parser
// no dependencies

package jssp_pkg;

    localparam int ENTRY_W       = 8;
    localparam int STACK_DEPTH_D = 64;
    localparam int DEPTH_W       = 7;

    // handler kinds
    localparam logic [2:0] K_TOP     = 3'd0;
    localparam logic [2:0] K_VALUE   = 3'd1;
    localparam logic [2:0] K_STRING  = 3'd2;
    localparam logic [2:0] K_ESCAPE  = 3'd3;
    localparam logic [2:0] K_NUMBER  = 3'd4;
    localparam logic [2:0] K_LITERAL = 3'd5;
    localparam logic [2:0] K_OBJECT  = 3'd6;
    localparam logic [2:0] K_ARRAY   = 3'd7;

    // object substates
    localparam logic [4:0] OB_KEY             = 5'd0;
    localparam logic [4:0] OB_KEY_AFTER_COMMA = 5'd1;
    localparam logic [4:0] OB_VALUE           = 5'd2;
    localparam logic [4:0] OB_COLON           = 5'd3;
    localparam logic [4:0] OB_COMMA           = 5'd4;
    // array substates
    localparam logic [4:0] AR_VALUE             = 5'd0;
    localparam logic [4:0] AR_VALUE_AFTER_COMMA = 5'd1;
    localparam logic [4:0] AR_COMMA             = 5'd2;
    // number substate bits
    localparam logic [4:0] NUM_SIGN_OK = 5'd1;
    localparam logic [4:0] NUM_EXP     = 5'd2;

    // opened value kinds
    localparam logic [2:0] OPEN_NONE   = 3'd0;
    localparam logic [2:0] OPEN_STRING = 3'd1;
    localparam logic [2:0] OPEN_NUMBER = 3'd2;
    localparam logic [2:0] OPEN_TRUE   = 3'd3;
    localparam logic [2:0] OPEN_FALSE  = 3'd4;
    localparam logic [2:0] OPEN_NULL   = 3'd5;
    localparam logic [2:0] OPEN_OBJECT = 3'd6;
    localparam logic [2:0] OPEN_ARRAY  = 3'd7;

    // error codes
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_UNEXPECTED    = 4'd1;
    localparam logic [3:0] ERR_TRAILING      = 4'd2;
    localparam logic [3:0] ERR_LEADING       = 4'd3;
    localparam logic [3:0] ERR_DOUBLE_COMMA  = 4'd4;
    localparam logic [3:0] ERR_MISSING_COMMA = 4'd5;
    localparam logic [3:0] ERR_COMMA_COLON   = 4'd6;
    localparam logic [3:0] ERR_INTERNAL      = 4'd7;
    localparam logic [3:0] ERR_OVERFLOW      = 4'd8;

    localparam logic [3:0] ITER_MAX = 4'd8;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;

    typedef struct packed {
        logic load;
        logic handle;
        logic fail_internal;
        logic pop_apply;
        logic count;
        logic last_pop;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic err_active;
        logic hdl_pop;
        logic hdl_again;
        logic sp_gt1;
        logic last;
    } dp_status_t;

    function automatic logic [7:0] mk_entry(input logic [2:0] kind, input logic [4:0] sub);
        return {sub, kind};
    endfunction

    // remaining letters of true, false, null; zero past the end
    function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (which)
            2'd0: begin
                case (pos)
                    3'd0: ch = "r";
                    3'd1: ch = "u";
                    3'd2: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (pos)
                    3'd0: ch = "a";
                    3'd1: ch = "l";
                    3'd2: ch = "s";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            2'd2: begin
                case (pos)
                    3'd0: ch = "u";
                    3'd1: ch = "l";
                    3'd2: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: src/json_syntax_stack_parser_core.sv
`timescale 1ns / 1ps
// top level of the json syntax stack parser
// depends on jssp_pkg, jssp_ctrl, jssp_dpath, jssp_ram

// Checks a JSON document fed one byte per transaction and returns one result
// per byte: the value kind opened, pops done, stack depth, line, column and a
// sticky error code. On the byte flagged last it also does the closing pop,
// reports doc_done and returns to the reset state. After acceptance a byte
// runs through the handler steps, a pop state for each pop (for the registered
// read of the stack ram), the counting state, the closing pop if any and then
// the result transaction. The handler state also makes a check pass when the
// byte is handed back after an error, when the hand-back limit is reached, or
// when an earlier error has already frozen the parse. The input is ready again
// only after the result transaction completes, so the parser takes a new byte
// only once it is through with the last one. No clearing pass is needed after
// reset.
module json_syntax_stack_parser_core #(
    parameter int STACK_DEPTH = jssp_pkg::STACK_DEPTH_D
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_opened_kind,
    output logic [2:0]  m_pops_done,
    output logic [6:0]  m_nest_depth,
    output logic [31:0] m_line_no,
    output logic [31:0] m_column_no,
    output logic [3:0]  m_error_code,
    output logic        m_doc_done
);

    jssp_pkg::ctl_cmd_t   cmd;
    jssp_pkg::dp_status_t st;

    jssp_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .st     (st),
        .cmd    (cmd)
    );

    jssp_dpath #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .st           (st),
        .s_byte_in    (s_byte_in),
        .s_last_byte  (s_last_byte),
        .m_opened_kind(m_opened_kind),
        .m_pops_done  (m_pops_done),
        .m_nest_depth (m_nest_depth),
        .m_line_no    (m_line_no),
        .m_column_no  (m_column_no),
        .m_error_code (m_error_code),
        .m_doc_done   (m_doc_done)
    );

endmodule

// File: src/jssp_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module jssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/jssp_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the parser: accept, handler steps, pops, counting, result
// depends on jssp_pkg

module jssp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  jssp_pkg::dp_status_t st,
    output jssp_pkg::ctl_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HANDLE = 3'd1;
    localparam logic [2:0] S_POP    = 3'd2;
    localparam logic [2:0] S_COUNT  = 3'd3;
    localparam logic [2:0] S_LPOP   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [3:0] n_reg, n_next;
    logic       again_reg, again_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            n_reg     <= 4'd0;
            again_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            again_reg <= again_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        n_next     = n_reg;
        again_next = again_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    n_next     = 4'd0;
                    state_next = S_HANDLE;
                end
            end
            S_HANDLE: begin
                if (st.err_active) begin
                    state_next = S_COUNT;
                end else if (n_reg == jssp_pkg::ITER_MAX) begin
                    cmd.fail_internal = 1'b1;
                    state_next        = S_COUNT;
                end else begin
                    cmd.handle = 1'b1;
                    n_next     = n_reg + 4'd1;
                    again_next = st.hdl_again;
                    if (st.hdl_pop) begin
                        state_next = S_POP;
                    end else if (!st.hdl_again) begin
                        state_next = S_COUNT;
                    end
                end
            end
            S_POP: begin
                cmd.pop_apply = 1'b1;
                state_next    = again_reg ? S_HANDLE : S_COUNT;
            end
            S_COUNT: begin
                cmd.count = 1'b1;
                if (st.last && !st.err_active && st.sp_gt1) begin
                    cmd.last_pop = 1'b1;
                    state_next   = S_LPOP;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_LPOP: begin
                cmd.pop_apply = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/jssp_dpath.sv
`timescale 1ns / 1ps
// parser datapath: cached stack top, stack ram, handler decode, counters
// depends on jssp_pkg and jssp_ram

module jssp_dpath #(
    parameter int STACK_DEPTH = jssp_pkg::STACK_DEPTH_D
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  jssp_pkg::ctl_cmd_t   cmd,
    output jssp_pkg::dp_status_t st,
    input  logic [7:0]           s_byte_in,
    input  logic                 s_last_byte,
    output logic [2:0]           m_opened_kind,
    output logic [2:0]           m_pops_done,
    output logic [6:0]           m_nest_depth,
    output logic [31:0]          m_line_no,
    output logic [31:0]          m_column_no,
    output logic [3:0]           m_error_code,
    output logic                 m_doc_done
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    logic [7:0]      byte_reg;
    logic            last_reg;
    logic [7:0]      top_reg, top_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [31:0]     line_reg, line_next;
    logic [31:0]     col_reg, col_next;
    logic [3:0]      err_reg, err_next;
    logic [2:0]      opened_reg, opened_next;
    logic [2:0]      pops_reg, pops_next;
    logic            nl_reg, nl_next;

    logic            ram_we;
    logic [7:0]      ram_wdata, ram_rdata;
    logic [SP_W-1:0] wsum, rsum;
    logic [AW-1:0]   ram_waddr, ram_raddr;

    logic            sp_gt1, sp_full;

    // handler step outcome
    logic       h_top_wr, h_push, h_pop, h_again, h_nl;
    logic [7:0] h_top_new, h_push_entry;
    logic [2:0] h_open;
    logic [3:0] h_fail;
    // value start outcome
    logic       ov_push, ov_again, ov_nl;
    logic [7:0] ov_entry;
    logic [2:0] ov_open;
    logic [3:0] ov_fail;

    logic [2:0] kind;
    logic [4:0] sub;
    logic [7:0] c;
    logic [7:0] want;
    logic [7:0] top_mod;
    logic [2:0] p_kind;
    logic [4:0] p_sub;

    assign c    = byte_reg;
    assign kind = top_reg[2:0];
    assign sub  = top_reg[7:3];
    assign want = jssp_pkg::lit_char(sub[1:0], sub[4:2]);

    assign sp_gt1    = sp_reg > SP_W'(1);
    assign sp_full   = sp_reg >= SP_W'(STACK_DEPTH);
    assign wsum      = sp_reg - SP_W'(1);
    assign rsum      = sp_reg - SP_W'(2);
    assign ram_waddr = wsum[AW-1:0];
    assign ram_raddr = rsum[AW-1:0];

    jssp_ram #(
        .WIDTH(jssp_pkg::ENTRY_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // start of a value
    always_comb begin
        ov_push  = 1'b0;
        ov_again = 1'b0;
        ov_nl    = 1'b0;
        ov_entry = '0;
        ov_open  = jssp_pkg::OPEN_NONE;
        ov_fail  = jssp_pkg::ERR_NONE;
        if (c == jssp_pkg::CH_QUOTE) begin
            ov_push  = 1'b1;
            ov_entry = jssp_pkg::mk_entry(jssp_pkg::K_STRING, 5'd0);
            ov_open  = jssp_pkg::OPEN_STRING;
        end else if (c inside {jssp_pkg::CH_MINUS, jssp_pkg::CH_PLUS, jssp_pkg::CH_DOT,
                               [8'h30:8'h39]}) begin
            ov_push  = 1'b1;
            ov_again = 1'b1;
            ov_entry = jssp_pkg::mk_entry(jssp_pkg::K_NUMBER, jssp_pkg::NUM_SIGN_OK);
            ov_open  = jssp_pkg::OPEN_NUMBER;
        end else if (c == "t") begin
            ov_push  = 1'b1;
            ov_entry = jssp_pkg::mk_entry(jssp_pkg::K_LITERAL, 5'd0);
            ov_open  = jssp_pkg::OPEN_TRUE;
        end else if (c == "f") begin
            ov_push  = 1'b1;
            ov_entry = jssp_pkg::mk_entry(jssp_pkg::K_LITERAL, 5'd1);
            ov_open  = jssp_pkg::OPEN_FALSE;
        end else if (c == "n") begin
            ov_push  = 1'b1;
            ov_entry = jssp_pkg::mk_entry(jssp_pkg::K_LITERAL, 5'd2);
            ov_open  = jssp_pkg::OPEN_NULL;
        end else if (c == jssp_pkg::CH_LBRACE) begin
            ov_push  = 1'b1;
            ov_entry = jssp_pkg::mk_entry(jssp_pkg::K_OBJECT, jssp_pkg::OB_KEY);
            ov_open  = jssp_pkg::OPEN_OBJECT;
        end else if (c == jssp_pkg::CH_LBRACK) begin
            ov_push  = 1'b1;
            ov_entry = jssp_pkg::mk_entry(jssp_pkg::K_ARRAY, jssp_pkg::AR_VALUE);
            ov_open  = jssp_pkg::OPEN_ARRAY;
        end else if (c == jssp_pkg::CH_NL) begin
            ov_nl = 1'b1;
        end else if (!(c inside {jssp_pkg::CH_SPACE, jssp_pkg::CH_TAB, jssp_pkg::CH_CR})) begin
            ov_fail = jssp_pkg::ERR_UNEXPECTED;
        end
    end

    // one handler step on the stack top
    always_comb begin
        h_top_wr     = 1'b0;
        h_top_new    = top_reg;
        h_push       = 1'b0;
        h_push_entry = '0;
        h_open       = jssp_pkg::OPEN_NONE;
        h_pop        = 1'b0;
        h_again      = 1'b0;
        h_nl         = 1'b0;
        h_fail       = jssp_pkg::ERR_NONE;
        case (kind)
            jssp_pkg::K_TOP, jssp_pkg::K_VALUE: begin
                if (sub[0] && kind == jssp_pkg::K_VALUE) begin
                    h_pop   = 1'b1;
                    h_again = 1'b1;
                end else if (sub[0]) begin
                    // value already read: whitespace only
                    if (c == jssp_pkg::CH_NL) begin
                        h_nl = 1'b1;
                    end else if (!(c inside {jssp_pkg::CH_SPACE, jssp_pkg::CH_TAB,
                                             jssp_pkg::CH_CR})) begin
                        h_fail = jssp_pkg::ERR_UNEXPECTED;
                    end
                end else begin
                    h_push       = ov_push;
                    h_push_entry = ov_entry;
                    h_open       = ov_open;
                    h_again      = ov_again;
                    h_nl         = ov_nl;
                    h_fail       = ov_fail;
                end
            end
            jssp_pkg::K_STRING: begin
                if (c == jssp_pkg::CH_QUOTE) begin
                    h_pop = 1'b1;
                end else if (c == jssp_pkg::CH_BSLASH) begin
                    h_push       = 1'b1;
                    h_push_entry = jssp_pkg::mk_entry(jssp_pkg::K_ESCAPE, 5'd0);
                end else if (c == jssp_pkg::CH_NL) begin
                    h_nl = 1'b1;
                end
            end
            jssp_pkg::K_ESCAPE: begin
                h_pop = 1'b1;
            end
            jssp_pkg::K_NUMBER: begin
                if (c inside {[8'h30:8'h39]}) begin
                    h_top_wr  = 1'b1;
                    h_top_new = jssp_pkg::mk_entry(kind, sub & ~jssp_pkg::NUM_SIGN_OK);
                end else if (c == jssp_pkg::CH_DOT) begin
                    if ((sub & jssp_pkg::NUM_EXP) != 5'd0) begin
                        h_fail = jssp_pkg::ERR_UNEXPECTED;
                    end else begin
                        h_top_wr  = 1'b1;
                        h_top_new = jssp_pkg::mk_entry(kind, sub & ~jssp_pkg::NUM_SIGN_OK);
                    end
                end else if (c == "e" || c == "E") begin
                    h_top_wr  = 1'b1;
                    h_top_new = jssp_pkg::mk_entry(kind,
                                                   jssp_pkg::NUM_EXP | jssp_pkg::NUM_SIGN_OK);
                end else if (c == jssp_pkg::CH_MINUS || c == jssp_pkg::CH_PLUS) begin
                    if ((sub & jssp_pkg::NUM_SIGN_OK) == 5'd0) begin
                        h_fail = jssp_pkg::ERR_UNEXPECTED;
                    end else begin
                        h_top_wr  = 1'b1;
                        h_top_new = jssp_pkg::mk_entry(kind, sub & ~jssp_pkg::NUM_SIGN_OK);
                    end
                end else begin
                    h_pop   = 1'b1;
                    h_again = 1'b1;
                end
            end
            jssp_pkg::K_LITERAL: begin
                if (sub[1:0] == 2'd3) begin
                    h_fail = jssp_pkg::ERR_INTERNAL;
                end else if (c inside {"r", "u", "e", "a", "l", "s"}) begin
                    if (want != c) begin
                        h_fail = jssp_pkg::ERR_UNEXPECTED;
                    end else begin
                        h_top_wr  = 1'b1;
                        h_top_new = jssp_pkg::mk_entry(kind, {sub[4:2] + 3'd1, sub[1:0]});
                    end
                end else if (want == 8'h00) begin
                    h_pop   = 1'b1;
                    h_again = 1'b1;
                end else begin
                    h_fail = jssp_pkg::ERR_UNEXPECTED;
                end
            end
            jssp_pkg::K_OBJECT: begin
                if (c == jssp_pkg::CH_RBRACE) begin
                    if (sub == jssp_pkg::OB_KEY || sub == jssp_pkg::OB_COMMA) begin
                        h_pop = 1'b1;
                    end else if (sub == jssp_pkg::OB_KEY_AFTER_COMMA) begin
                        h_fail = jssp_pkg::ERR_TRAILING;
                    end else begin
                        h_fail = jssp_pkg::ERR_UNEXPECTED;
                    end
                end else if (c == jssp_pkg::CH_COMMA) begin
                    case (sub)
                        jssp_pkg::OB_COMMA: begin
                            h_top_wr  = 1'b1;
                            h_top_new = jssp_pkg::mk_entry(kind, jssp_pkg::OB_KEY_AFTER_COMMA);
                        end
                        jssp_pkg::OB_KEY:             h_fail = jssp_pkg::ERR_LEADING;
                        jssp_pkg::OB_KEY_AFTER_COMMA: h_fail = jssp_pkg::ERR_DOUBLE_COMMA;
                        jssp_pkg::OB_COLON:           h_fail = jssp_pkg::ERR_COMMA_COLON;
                        default:                      h_fail = jssp_pkg::ERR_INTERNAL;
                    endcase
                end else if (c == jssp_pkg::CH_COLON) begin
                    if (sub == jssp_pkg::OB_COLON) begin
                        h_top_wr     = 1'b1;
                        h_top_new    = jssp_pkg::mk_entry(kind, jssp_pkg::OB_VALUE);
                        h_push       = 1'b1;
                        h_push_entry = jssp_pkg::mk_entry(jssp_pkg::K_VALUE, 5'd0);
                    end else begin
                        h_fail = jssp_pkg::ERR_UNEXPECTED;
                    end
                end else if (c == jssp_pkg::CH_QUOTE) begin
                    if (sub == jssp_pkg::OB_KEY || sub == jssp_pkg::OB_KEY_AFTER_COMMA ||
                        sub == jssp_pkg::OB_VALUE) begin
                        h_push       = 1'b1;
                        h_push_entry = jssp_pkg::mk_entry(jssp_pkg::K_STRING, 5'd0);
                        h_open       = jssp_pkg::OPEN_STRING;
                    end else if (sub == jssp_pkg::OB_COMMA) begin
                        h_fail = jssp_pkg::ERR_MISSING_COMMA;
                    end else begin
                        h_fail = jssp_pkg::ERR_UNEXPECTED;
                    end
                end else if (c == jssp_pkg::CH_NL) begin
                    h_nl = 1'b1;
                end else if (!(c inside {jssp_pkg::CH_SPACE, jssp_pkg::CH_TAB,
                                         jssp_pkg::CH_CR})) begin
                    h_fail = jssp_pkg::ERR_UNEXPECTED;
                end
            end
            default: begin
                // array
                if (c == jssp_pkg::CH_RBRACK) begin
                    if (sub == jssp_pkg::AR_VALUE_AFTER_COMMA) begin
                        h_fail = jssp_pkg::ERR_TRAILING;
                    end else begin
                        h_pop = 1'b1;
                    end
                end else if (c == jssp_pkg::CH_COMMA) begin
                    if (sub == jssp_pkg::AR_COMMA) begin
                        h_top_wr  = 1'b1;
                        h_top_new = jssp_pkg::mk_entry(kind, jssp_pkg::AR_VALUE_AFTER_COMMA);
                    end else if (sub == jssp_pkg::AR_VALUE) begin
                        h_fail = jssp_pkg::ERR_LEADING;
                    end else begin
                        h_fail = jssp_pkg::ERR_DOUBLE_COMMA;
                    end
                end else if (c == jssp_pkg::CH_NL) begin
                    h_nl = 1'b1;
                end else if (c == jssp_pkg::CH_SPACE || c == jssp_pkg::CH_TAB) begin
                    h_nl = 1'b0;
                end else if (sub == jssp_pkg::AR_COMMA) begin
                    h_fail = jssp_pkg::ERR_MISSING_COMMA;
                end else begin
                    h_top_wr     = 1'b1;
                    h_top_new    = jssp_pkg::mk_entry(kind, jssp_pkg::AR_COMMA);
                    h_push       = 1'b1;
                    h_push_entry = jssp_pkg::mk_entry(jssp_pkg::K_VALUE, 5'd0);
                    h_again      = 1'b1;
                end
            end
        endcase
    end

    assign top_mod = h_top_wr ? h_top_new : top_reg;
    assign p_kind  = ram_rdata[2:0];
    assign p_sub   = ram_rdata[7:3];

    always_comb begin
        top_next    = top_reg;
        sp_next     = sp_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        err_next    = err_reg;
        opened_next = opened_reg;
        pops_next   = pops_reg;
        nl_next     = nl_reg;
        ram_we      = 1'b0;
        ram_wdata   = top_mod;

        if (cmd.load) begin
            opened_next = jssp_pkg::OPEN_NONE;
            pops_next   = 3'd0;
            nl_next     = 1'b0;
        end

        if (cmd.handle) begin
            if (h_fail != jssp_pkg::ERR_NONE) begin
                err_next = h_fail;
            end
            if (h_nl) begin
                nl_next = 1'b1;
            end
            if (h_push) begin
                top_next = top_mod;
                if (sp_full) begin
                    err_next = jssp_pkg::ERR_OVERFLOW;
                end else begin
                    ram_we   = 1'b1;
                    top_next = h_push_entry;
                    sp_next  = sp_reg + SP_W'(1);
                    if (h_open != jssp_pkg::OPEN_NONE) begin
                        opened_next = h_open;
                    end
                end
            end else if (h_pop) begin
                if (sp_gt1) begin
                    sp_next   = sp_reg - SP_W'(1);
                    pops_next = pops_reg + 3'd1;
                end else begin
                    err_next = jssp_pkg::ERR_INTERNAL;
                end
            end else begin
                top_next = top_mod;
            end
        end

        if (cmd.fail_internal && err_reg == jssp_pkg::ERR_NONE) begin
            err_next = jssp_pkg::ERR_INTERNAL;
        end

        // parent comes back from the ram; a top, value or object parent learns a value arrived
        if (cmd.pop_apply) begin
            top_next = ram_rdata;
            if (p_kind == jssp_pkg::K_TOP || p_kind == jssp_pkg::K_VALUE) begin
                top_next = jssp_pkg::mk_entry(p_kind, p_sub | 5'd1);
            end else if (p_kind == jssp_pkg::K_OBJECT) begin
                if (p_sub == jssp_pkg::OB_KEY || p_sub == jssp_pkg::OB_KEY_AFTER_COMMA) begin
                    top_next = jssp_pkg::mk_entry(p_kind, jssp_pkg::OB_COLON);
                end else if (p_sub == jssp_pkg::OB_VALUE) begin
                    top_next = jssp_pkg::mk_entry(p_kind, jssp_pkg::OB_COMMA);
                end else if (err_reg == jssp_pkg::ERR_NONE) begin
                    err_next = jssp_pkg::ERR_INTERNAL;
                end
            end
        end

        if (cmd.count && err_reg == jssp_pkg::ERR_NONE) begin
            if (nl_reg) begin
                if (line_reg != 32'hffff_ffff) begin
                    line_next = line_reg + 32'd1;
                end
                col_next = 32'd1;
            end else if (col_reg != 32'hffff_ffff) begin
                col_next = col_reg + 32'd1;
            end
        end

        if (cmd.last_pop) begin
            sp_next   = sp_reg - SP_W'(1);
            pops_next = pops_reg + 3'd1;
        end

        if (cmd.finish && last_reg) begin
            top_next  = jssp_pkg::mk_entry(jssp_pkg::K_TOP, 5'd0);
            sp_next   = SP_W'(1);
            line_next = 32'd1;
            col_next  = 32'd1;
            err_next  = jssp_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg    <= jssp_pkg::mk_entry(jssp_pkg::K_TOP, 5'd0);
            sp_reg     <= SP_W'(1);
            line_reg   <= 32'd1;
            col_reg    <= 32'd1;
            err_reg    <= jssp_pkg::ERR_NONE;
            opened_reg <= jssp_pkg::OPEN_NONE;
            pops_reg   <= 3'd0;
            nl_reg     <= 1'b0;
        end else begin
            top_reg    <= top_next;
            sp_reg     <= sp_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            err_reg    <= err_next;
            opened_reg <= opened_next;
            pops_reg   <= pops_next;
            nl_reg     <= nl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= s_byte_in;
            last_reg <= s_last_byte;
        end
    end

    assign st.err_active = err_reg != jssp_pkg::ERR_NONE;
    assign st.hdl_pop    = h_pop && sp_gt1;
    assign st.hdl_again  = h_again;
    assign st.sp_gt1     = sp_gt1;
    assign st.last       = last_reg;

    assign m_opened_kind = opened_reg;
    assign m_pops_done   = pops_reg;
    assign m_nest_depth  = jssp_pkg::DEPTH_W'(sp_reg);
    assign m_line_no     = line_reg;
    assign m_column_no   = col_reg;
    assign m_error_code  = err_reg;
    assign m_doc_done    = last_reg && err_reg == jssp_pkg::ERR_NONE &&
                           sp_reg == SP_W'(1) && top_reg[3];

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg >= SP_W'(1) && sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer out of range");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != jssp_pkg::ERR_NONE && !cmd.finish |=> err_reg == $past(err_reg))
        else $error("error code changed before document end");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> sp_reg == $past(sp_reg) + SP_W'(1))
        else $error("stack write without depth increment");

    // while a pop is being applied the cached top still holds the closed child
    a_bottom_top: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg == SP_W'(1) && !cmd.pop_apply |-> top_reg[2:0] == jssp_pkg::K_TOP)
        else $error("bottom entry is not the top handler");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for json_syntax_stack_parser_core
// depends on jssp_pkg and the parser rtl; a local syntax predictor checks each result

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_ITEMS        = 1950;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte_in;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_opened_kind;
    logic [2:0]  m_pops_done;
    logic [6:0]  m_nest_depth;
    logic [31:0] m_line_no;
    logic [31:0] m_column_no;
    logic [3:0]  m_error_code;
    logic        m_doc_done;

    json_syntax_stack_parser_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_byte_in(s_byte_in), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_opened_kind(m_opened_kind), .m_pops_done(m_pops_done),
        .m_nest_depth(m_nest_depth), .m_line_no(m_line_no),
        .m_column_no(m_column_no), .m_error_code(m_error_code),
        .m_doc_done(m_doc_done)
    );

    typedef struct packed {
        logic [2:0]  opened;
        logic [2:0]  pops;
        logic [6:0]  depth;
        logic [31:0] line;
        logic [31:0] col;
        logic [3:0]  err;
        logic        done;
    } parse_result_t;

    typedef struct {
        logic [7:0]    ch;
        logic          last;
        logic          typed;
        parse_result_t res;
    } stim_row_t;

    // predictor state
    logic [7:0]  pstack [jssp_pkg::STACK_DEPTH_D];
    int unsigned psp;
    logic [31:0] pline;
    logic [31:0] pcol;
    logic [3:0]  perr;
    logic [2:0]  s_opened;
    int unsigned s_pops;
    bit          s_nl;

    parse_result_t results_due[$];
    parse_result_t typed_due[$];
    bit            typed_flag[$];

    int errors;
    int bytes_sent;
    int docs_done_seen;
    int errs_seen;
    int idle_cycles;

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    function automatic void parser_reset();
        for (int i = 0; i < jssp_pkg::STACK_DEPTH_D; i++) pstack[i] = 8'h00;
        pstack[0] = {5'd0, jssp_pkg::K_TOP};
        psp = 1;
        pline = 32'd1;
        pcol = 32'd1;
        perr = jssp_pkg::ERR_NONE;
    endfunction

    function automatic void flag_err(logic [3:0] code);
        if (perr == jssp_pkg::ERR_NONE) perr = code;
    endfunction

    function automatic void push_h(logic [2:0] kind, logic [4:0] sub, logic [2:0] opened);
        if (psp >= jssp_pkg::STACK_DEPTH_D) begin
            flag_err(jssp_pkg::ERR_OVERFLOW);
            return;
        end
        pstack[psp] = {sub, kind};
        psp++;
        if (opened != jssp_pkg::OPEN_NONE) s_opened = opened;
    endfunction

    function automatic void pop_h();
        logic [2:0] kind;
        logic [4:0] sub;
        if (psp <= 1) begin
            flag_err(jssp_pkg::ERR_INTERNAL);
            return;
        end
        psp--;
        s_pops++;
        kind = pstack[psp-1][2:0];
        sub = pstack[psp-1][7:3];
        if (kind == jssp_pkg::K_TOP || kind == jssp_pkg::K_VALUE) begin
            pstack[psp-1] = {sub | 5'd1, kind};
        end else if (kind == jssp_pkg::K_OBJECT) begin
            if (sub == jssp_pkg::OB_KEY || sub == jssp_pkg::OB_KEY_AFTER_COMMA)
                pstack[psp-1] = {jssp_pkg::OB_COLON, kind};
            else if (sub == jssp_pkg::OB_VALUE) pstack[psp-1] = {jssp_pkg::OB_COMMA, kind};
            else flag_err(jssp_pkg::ERR_INTERNAL);
        end
    endfunction

    function automatic void blank(logic [7:0] c);
        if (c == jssp_pkg::CH_SPACE || c == jssp_pkg::CH_TAB || c == jssp_pkg::CH_CR) return;
        if (c == jssp_pkg::CH_NL) s_nl = 1;
        else flag_err(jssp_pkg::ERR_UNEXPECTED);
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit begin_value(logic [7:0] c);
        if (c == jssp_pkg::CH_QUOTE) begin
            push_h(jssp_pkg::K_STRING, 5'd0, jssp_pkg::OPEN_STRING);
            return 0;
        end
        if (c == jssp_pkg::CH_MINUS || c == jssp_pkg::CH_PLUS || c == jssp_pkg::CH_DOT ||
            digit(c)) begin
            push_h(jssp_pkg::K_NUMBER, jssp_pkg::NUM_SIGN_OK, jssp_pkg::OPEN_NUMBER);
            return 1;
        end
        if (c == "t") push_h(jssp_pkg::K_LITERAL, 5'd0, jssp_pkg::OPEN_TRUE);
        else if (c == "f") push_h(jssp_pkg::K_LITERAL, 5'd1, jssp_pkg::OPEN_FALSE);
        else if (c == "n") push_h(jssp_pkg::K_LITERAL, 5'd2, jssp_pkg::OPEN_NULL);
        else if (c == jssp_pkg::CH_LBRACE)
            push_h(jssp_pkg::K_OBJECT, jssp_pkg::OB_KEY, jssp_pkg::OPEN_OBJECT);
        else if (c == jssp_pkg::CH_LBRACK)
            push_h(jssp_pkg::K_ARRAY, jssp_pkg::AR_VALUE, jssp_pkg::OPEN_ARRAY);
        else blank(c);
        return 0;
    endfunction

    // one handler step on the top entry; returns 1 when the byte is handed back
    function automatic bit step_top(logic [7:0] c);
        logic [2:0] kind;
        logic [4:0] sub;
        logic [1:0] which;
        logic [2:0] pos;
        logic [7:0] want;
        kind = pstack[psp-1][2:0];
        sub = pstack[psp-1][7:3];
        case (kind)
            jssp_pkg::K_TOP: begin
                if (sub[0]) begin
                    blank(c);
                    return 0;
                end
                return begin_value(c);
            end
            jssp_pkg::K_VALUE: begin
                if (sub[0]) begin
                    pop_h();
                    return 1;
                end
                return begin_value(c);
            end
            jssp_pkg::K_STRING: begin
                if (c == jssp_pkg::CH_QUOTE) pop_h();
                else if (c == jssp_pkg::CH_BSLASH)
                    push_h(jssp_pkg::K_ESCAPE, 5'd0, jssp_pkg::OPEN_NONE);
                else if (c == jssp_pkg::CH_NL) s_nl = 1;
                return 0;
            end
            jssp_pkg::K_ESCAPE: begin
                pop_h();
                return 0;
            end
            jssp_pkg::K_NUMBER: begin
                if (digit(c)) sub &= ~jssp_pkg::NUM_SIGN_OK;
                else if (c == jssp_pkg::CH_DOT) begin
                    if ((sub & jssp_pkg::NUM_EXP) != 5'd0) begin
                        flag_err(jssp_pkg::ERR_UNEXPECTED);
                        return 0;
                    end
                    sub &= ~jssp_pkg::NUM_SIGN_OK;
                end else if (c == "e" || c == "E") begin
                    sub = jssp_pkg::NUM_EXP | jssp_pkg::NUM_SIGN_OK;
                end else if (c == jssp_pkg::CH_MINUS || c == jssp_pkg::CH_PLUS) begin
                    if ((sub & jssp_pkg::NUM_SIGN_OK) == 5'd0) begin
                        flag_err(jssp_pkg::ERR_UNEXPECTED);
                        return 0;
                    end
                    sub &= ~jssp_pkg::NUM_SIGN_OK;
                end else begin
                    pop_h();
                    return 1;
                end
                pstack[psp-1] = {sub, kind};
                return 0;
            end
            jssp_pkg::K_LITERAL: begin
                which = sub[1:0];
                pos = sub[4:2];
                if (which > 2'd2) begin
                    flag_err(jssp_pkg::ERR_INTERNAL);
                    return 0;
                end
                case (which)
                    2'd0: want = pos == 0 ? "r" : pos == 1 ? "u" : pos == 2 ? "e" : 8'h00;
                    2'd1: want = pos == 0 ? "a" : pos == 1 ? "l" : pos == 2 ? "s" :
                                 pos == 3 ? "e" : 8'h00;
                    default: want = pos == 0 ? "u" : pos == 1 ? "l" : pos == 2 ? "l" : 8'h00;
                endcase
                if (c == "r" || c == "u" || c == "e" || c == "a" || c == "l" || c == "s") begin
                    if (want != c) begin
                        flag_err(jssp_pkg::ERR_UNEXPECTED);
                        return 0;
                    end
                    pstack[psp-1] = {pos + 3'd1, which, kind};
                    return 0;
                end
                if (want == 8'h00) begin
                    pop_h();
                    return 1;
                end
                flag_err(jssp_pkg::ERR_UNEXPECTED);
                return 0;
            end
            jssp_pkg::K_OBJECT: begin
                if (c == jssp_pkg::CH_RBRACE) begin
                    if (sub == jssp_pkg::OB_KEY || sub == jssp_pkg::OB_COMMA) pop_h();
                    else if (sub == jssp_pkg::OB_KEY_AFTER_COMMA)
                        flag_err(jssp_pkg::ERR_TRAILING);
                    else flag_err(jssp_pkg::ERR_UNEXPECTED);
                end else if (c == jssp_pkg::CH_COMMA) begin
                    if (sub == jssp_pkg::OB_COMMA)
                        pstack[psp-1] = {jssp_pkg::OB_KEY_AFTER_COMMA, kind};
                    else if (sub == jssp_pkg::OB_KEY) flag_err(jssp_pkg::ERR_LEADING);
                    else if (sub == jssp_pkg::OB_KEY_AFTER_COMMA)
                        flag_err(jssp_pkg::ERR_DOUBLE_COMMA);
                    else if (sub == jssp_pkg::OB_COLON) flag_err(jssp_pkg::ERR_COMMA_COLON);
                    else flag_err(jssp_pkg::ERR_INTERNAL);
                end else if (c == jssp_pkg::CH_COLON) begin
                    if (sub == jssp_pkg::OB_COLON) begin
                        pstack[psp-1] = {jssp_pkg::OB_VALUE, kind};
                        push_h(jssp_pkg::K_VALUE, 5'd0, jssp_pkg::OPEN_NONE);
                    end else flag_err(jssp_pkg::ERR_UNEXPECTED);
                end else if (c == jssp_pkg::CH_QUOTE) begin
                    if (sub == jssp_pkg::OB_KEY || sub == jssp_pkg::OB_KEY_AFTER_COMMA ||
                        sub == jssp_pkg::OB_VALUE)
                        push_h(jssp_pkg::K_STRING, 5'd0, jssp_pkg::OPEN_STRING);
                    else if (sub == jssp_pkg::OB_COMMA) flag_err(jssp_pkg::ERR_MISSING_COMMA);
                    else flag_err(jssp_pkg::ERR_UNEXPECTED);
                end else blank(c);
                return 0;
            end
            default: begin
                if (c == jssp_pkg::CH_RBRACK) begin
                    if (sub == jssp_pkg::AR_VALUE_AFTER_COMMA) flag_err(jssp_pkg::ERR_TRAILING);
                    else pop_h();
                end else if (c == jssp_pkg::CH_COMMA) begin
                    if (sub == jssp_pkg::AR_COMMA)
                        pstack[psp-1] = {jssp_pkg::AR_VALUE_AFTER_COMMA, kind};
                    else if (sub == jssp_pkg::AR_VALUE) flag_err(jssp_pkg::ERR_LEADING);
                    else flag_err(jssp_pkg::ERR_DOUBLE_COMMA);
                end else if (c == jssp_pkg::CH_NL) s_nl = 1;
                else if (c == jssp_pkg::CH_SPACE || c == jssp_pkg::CH_TAB) begin
                end else begin
                    if (sub == jssp_pkg::AR_COMMA) begin
                        flag_err(jssp_pkg::ERR_MISSING_COMMA);
                        return 0;
                    end
                    pstack[psp-1] = {jssp_pkg::AR_COMMA, kind};
                    push_h(jssp_pkg::K_VALUE, 5'd0, jssp_pkg::OPEN_NONE);
                    return 1;
                end
                return 0;
            end
        endcase
    endfunction

    function automatic parse_result_t parse_byte(logic [7:0] c, logic last);
        parse_result_t r;
        bit again;
        int n;
        s_opened = jssp_pkg::OPEN_NONE;
        s_pops = 0;
        s_nl = 0;
        if (perr == jssp_pkg::ERR_NONE) begin
            again = 1;
            n = 0;
            while (again && perr == jssp_pkg::ERR_NONE) begin
                if (n >= jssp_pkg::ITER_MAX) begin
                    flag_err(jssp_pkg::ERR_INTERNAL);
                    break;
                end
                n++;
                again = step_top(c);
            end
            if (perr == jssp_pkg::ERR_NONE) begin
                if (s_nl) begin
                    if (pline != 32'hFFFF_FFFF) pline++;
                    pcol = 32'd1;
                end else if (pcol != 32'hFFFF_FFFF) pcol++;
            end
        end
        r.done = 1'b0;
        if (last) begin
            if (perr == jssp_pkg::ERR_NONE && psp > 1) pop_h();
            r.done = perr == jssp_pkg::ERR_NONE && pstack[0][3];
        end
        r.opened = s_opened;
        r.pops = s_pops[2:0];
        r.depth = psp[6:0];
        r.line = pline;
        r.col = pcol;
        r.err = perr;
        if (last) parser_reset();
        return r;
    endfunction

    function automatic parse_result_t mk_res(logic [2:0] o, logic [2:0] p, logic [6:0] d,
                                             logic [31:0] l, logic [31:0] cl, logic [3:0] e,
                                             logic dn);
        parse_result_t r;
        r = '{o, p, d, l, cl, e, dn};
        return r;
    endfunction

    // directed rows; a typed row is also compared against the predictor
    stim_row_t dir_rows[$];

    function automatic void add_row(logic [7:0] c, logic last, bit typed = 0,
                                    parse_result_t r = '0);
        stim_row_t row;
        row.ch = c;
        row.last = last;
        row.typed = typed;
        row.res = r;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_text(string txt, bit end_doc);
        for (int i = 0; i < txt.len(); i++)
            add_row(txt[i], end_doc && i == txt.len() - 1);
    endfunction

    // called at a falling edge; leaves valid high until the next call or the end
    task automatic send_byte(logic [7:0] c, logic last);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_byte_in <= c;
        s_last_byte <= last;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic feed(logic [7:0] c, logic last, bit typed, parse_result_t r);
        results_due.push_back(parse_byte(c, last));
        typed_flag.push_back(typed);
        typed_due.push_back(r);
        send_byte(c, last);
    endtask

    task automatic feed_text(string txt, bit end_doc);
        for (int i = 0; i < txt.len(); i++)
            feed(txt[i], end_doc && i == txt.len() - 1, 1'b0, '0);
    endtask

    function automatic string rand_piece(int lvl);
        string s;
        int k;
        k = $urandom_range(0, lvl > 3 ? 5 : 8);
        case (k)
            0: s = "\"a\\\"b c\"";
            1: s = $sformatf("%0d", $urandom_range(0, 99999));
            2: s = $sformatf("-%0d.%0de+%0d", $urandom_range(0, 99), $urandom_range(0, 9),
                             $urandom_range(0, 9));
            3: s = "true";
            4: s = "false";
            5: s = "null";
            6: begin
                s = "[";
                for (int i = $urandom_range(0, 3); i > 0; i--) begin
                    s = {s, rand_piece(lvl + 1)};
                    if (i > 1) s = {s, ", "};
                end
                s = {s, "]"};
            end
            default: begin
                s = "{";
                for (int i = $urandom_range(0, 3); i > 0; i--) begin
                    s = {s, "\"k\":\n", rand_piece(lvl + 1)};
                    if (i > 1) s = {s, ","};
                end
                s = {s, "}"};
            end
        endcase
        return s;
    endfunction

    // output side: random stalls, compare in order
    initial begin
        parse_result_t e;
        parse_result_t t;
        bit tf;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(0, 18)) @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (results_due.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = results_due.pop_front();
                t = typed_due.pop_front();
                tf = typed_flag.pop_front();
                if (tf && t != e) begin
                    $error("typed row disagrees with predictor: %h vs %h", t, e);
                    errors++;
                end
                if (m_opened_kind !== e.opened) begin
                    $error("opened_kind exp %0d got %0d", e.opened, m_opened_kind); errors++;
                end
                if (m_pops_done !== e.pops) begin
                    $error("pops_done exp %0d got %0d", e.pops, m_pops_done); errors++;
                end
                if (m_nest_depth !== e.depth) begin
                    $error("nest_depth exp %0d got %0d", e.depth, m_nest_depth); errors++;
                end
                if (m_line_no !== e.line) begin
                    $error("line_no exp %0d got %0d", e.line, m_line_no); errors++;
                end
                if (m_column_no !== e.col) begin
                    $error("column_no exp %0d got %0d", e.col, m_column_no); errors++;
                end
                if (m_error_code !== e.err) begin
                    $error("error_code exp %0d got %0d", e.err, m_error_code); errors++;
                end
                if (m_doc_done !== e.done) begin
                    $error("doc_done exp %0d got %0d", e.done, m_doc_done); errors++;
                end
                if (e.done) docs_done_seen++;
                if (e.err != jssp_pkg::ERR_NONE) errs_seen++;
            end
            @(negedge aclk);
            m_ready <= 1'b0;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("json_syntax_stack_parser_core: mismatch");
            $finish;
        end
    end

    initial begin
        string doc;
        errors = 0;
        bytes_sent = 0;
        docs_done_seen = 0;
        errs_seen = 0;
        idle_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_byte_in = 8'h00;
        s_last_byte = 1'b0;
        parser_reset();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: single-byte docs, extremes, error codes and short documents
        add_row(8'h00, 1'b1, 1'b1, mk_res(jssp_pkg::OPEN_NONE, 3'd0, 7'd1, 32'd1, 32'd1,
                                          jssp_pkg::ERR_UNEXPECTED, 1'b0));
        add_row(8'hFF, 1'b1, 1'b1, mk_res(jssp_pkg::OPEN_NONE, 3'd0, 7'd1, 32'd1, 32'd1,
                                          jssp_pkg::ERR_UNEXPECTED, 1'b0));
        add_row("7", 1'b1, 1'b1, mk_res(jssp_pkg::OPEN_NUMBER, 3'd1, 7'd1, 32'd1, 32'd2,
                                        jssp_pkg::ERR_NONE, 1'b1));
        add_row("[", 1'b0, 1'b1, mk_res(jssp_pkg::OPEN_ARRAY, 3'd0, 7'd2, 32'd1, 32'd2,
                                        jssp_pkg::ERR_NONE, 1'b0));
        add_row(",", 1'b1, 1'b1, mk_res(jssp_pkg::OPEN_NONE, 3'd0, 7'd2, 32'd1, 32'd2,
                                        jssp_pkg::ERR_LEADING, 1'b0));
        add_text("{,", 1);
        add_text("[1,]", 1);
        add_text("[1,,", 1);
        add_text("{\"a\"\n,", 1);
        add_text("{\"a\":1\"", 1);
        add_text("[1 2", 1);
        add_text("t rue", 1);
        add_text("[1e5.", 1);
        add_text("\"x\\\"\"", 1);
        add_text("{\"k\":[-1.5E+3,false,null,true]}", 1);
        foreach (dir_rows[i]) feed(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed,
                                   dir_rows[i].res);
        // overflow: open arrays past the stack size
        for (int i = 0; i < 70; i++) feed(jssp_pkg::CH_LBRACK, i == 69, 1'b0, '0);

        // random: mostly well-formed docs, some corrupted, some raw noise
        while (bytes_sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0: for (int i = $urandom_range(1, 6); i > 0; i--)
                       feed(8'($urandom_range(0, 255)), i == 1, 1'b0, '0);
                1, 2: begin
                    doc = {" ", rand_piece(0)};
                    doc[$urandom_range(0, doc.len() - 1)] = 8'($urandom_range(0, 255));
                    feed_text(doc, 1);
                end
                default: begin
                    doc = {rand_piece(0), "\n "};
                    feed_text(doc, 1);
                end
            endcase
        end
        s_valid <= 1'b0;

        while (results_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("covered %0d bytes; %0d documents completed, %0d results with an error",
                 bytes_sent, docs_done_seen, errs_seen);
        if (errors == 0) begin
            $display("json_syntax_stack_parser_core: match");
        end else begin
            $display("json_syntax_stack_parser_core: mismatch");
        end
        $finish;
    end

endmodule
